@@ rtl/mst_pkg.sv @@
// Shared types and constants of the monitored station table.
// No dependencies; imported by every module of the block.
package mst_pkg;

  // command codes of the input transfer
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_QUERY   = 3'd2,
    CMD_FLUSH   = 3'd3,
    CMD_OBSERVE = 3'd4
  } mst_cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_MISS    = 2'd3
  } mst_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } mst_state_t;

  // configuration register byte offset bit and index
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam logic        REG_MON_EN    = 1'b0;

  // sinr mean: 32 bytes summed, four per step, then divided by 32
  localparam int unsigned SINR_STEPS    = 8;
  localparam int unsigned SINR_STEP_W   = 3;
  localparam int unsigned SINR_SUM_W    = 13;
  localparam int unsigned SINR_SHIFT    = 5;

  // input transfer payload
  typedef struct packed {
    logic [2:0]         command;
    logic [47:0]        station_address;
    logic               is_mpdu;
    logic signed [7:0]  signal_strength;
    logic               sinr_present;
    logic [63:0]        sinr_words_a;
    logic [63:0]        sinr_words_b;
    logic [63:0]        sinr_words_c;
    logic [63:0]        sinr_words_d;
    logic [31:0]        time_now;
  } mst_in_t;

  // result transfer payload
  typedef struct packed {
    logic [1:0]         status;
    logic signed [7:0]  stored_strength;
    logic [7:0]         stored_sinr;
    logic [31:0]        stored_time;
    logic [4:0]         entries_used;
  } mst_out_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [47:0]        address;
    logic signed [7:0]  strength;
    logic [7:0]         sinr;
    logic [31:0]        rx_time;
  } mst_entry_t;

  // status of the sinr accumulator
  typedef struct packed {
    logic               busy;
    logic [7:0]         mean;
  } mst_sinr_stat_t;

endpackage

@@ rtl/mst_entry_ram.sv @@
// Entry memory of the monitored station table: one write port, one read port,
// registered read data. Depends on mst_pkg for the entry type.
module mst_entry_ram
  import mst_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  mst_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output mst_entry_t    rdata
);

  mst_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mst_sinr_acc.sv @@
// Iterative sinr mean unit: sums the 32 bytes of the sinr words, four per
// cycle, and divides by 32. Depends on mst_pkg.
module mst_sinr_acc
  import mst_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [63:0]    words_a,
  input  logic [63:0]    words_b,
  input  logic [63:0]    words_c,
  input  logic [63:0]    words_d,
  output mst_sinr_stat_t stat
);

  logic                   run_r,  run_nxt;
  logic [SINR_STEP_W-1:0] step_r, step_nxt;
  logic [SINR_SUM_W-1:0]  sum_r,  sum_nxt;
  logic [5:0]             lsb;
  logic [SINR_SUM_W-1:0]  step_sum;

  // byte of each word group taken in this step
  assign lsb      = {step_r, 3'b000};
  assign step_sum = SINR_SUM_W'(words_a[lsb +: 8]) + SINR_SUM_W'(words_b[lsb +: 8])
                  + SINR_SUM_W'(words_c[lsb +: 8]) + SINR_SUM_W'(words_d[lsb +: 8]);

  // accumulation control
  always_comb begin
    run_nxt  = run_r;
    step_nxt = step_r;
    sum_nxt  = sum_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      sum_nxt  = '0;
    end else if (run_r) begin
      sum_nxt  = sum_r + step_sum;
      step_nxt = step_r + 1'b1;
      if (step_r == SINR_STEP_W'(SINR_STEPS - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign stat.busy = run_r;
  assign stat.mean = sum_r[SINR_SHIFT +: 8];

endmodule

@@ rtl/mst_ctrl.sv @@
// Sequencer of the monitored station table: holds the item, walks the entry
// memory, keeps valid bits and the station count, and drives the result.
// Depends on mst_pkg; drives mst_entry_ram and mst_sinr_acc.
module mst_ctrl
  import mst_pkg::*;
#(
  parameter int unsigned N     = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mst_in_t        in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mst_out_t       out_data,
  input  logic           monitor_enable,
  output mst_in_t        item,
  output logic           sinr_start,
  input  mst_sinr_stat_t sinr_stat,
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output mst_entry_t     ram_wdata,
  output logic [AW-1:0]  ram_raddr,
  input  mst_entry_t     ram_rdata
);

  mst_state_t       state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             rd_pending_r, rd_pending_nxt;
  logic [AW-1:0]    rd_idx_r;
  logic [N-1:0]     valid_r, valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    match_idx_r, match_idx_nxt;
  mst_entry_t       match_r, match_nxt;
  logic             free_found_r, free_found_nxt;
  logic [AW-1:0]    free_idx_r, free_idx_nxt;
  mst_in_t          item_r;
  logic             out_valid_r, out_valid_nxt;
  mst_out_t         out_data_r, out_data_nxt;
  logic             accept, finish, out_free, hit, free_slot;
  logic [CNT_W+4:0] cnt_ext;
  mst_out_t         res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == S_FINISH) && !sinr_stat.busy && out_free;
  assign item     = item_r;

  // lookup on the entry coming back from the memory
  assign hit       = rd_pending_r && valid_r[rd_idx_r]
                     && (ram_rdata.address == item_r.station_address);
  assign free_slot = rd_pending_r && !valid_r[rd_idx_r];

  assign ram_raddr  = idx_r;
  assign sinr_start = accept;

  // sequencer and command execution
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rd_pending_nxt = (state_r == S_SCAN);
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_nxt      = match_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_waddr      = match_idx_r;
    ram_wdata      = '{address: item_r.station_address, strength: '0, sinr: '0,
                       rx_time: '0};
    res            = '{status: ST_MISS, stored_strength: '0, stored_sinr: '0,
                       stored_time: '0, entries_used: '0};

    // first matching and first free slot seen during the walk
    if (hit && !found_r) begin
      found_nxt     = 1'b1;
      match_idx_nxt = rd_idx_r;
      match_nxt     = ram_rdata;
    end
    if (free_slot && !free_found_r) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = rd_idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt      = S_SCAN;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (idx_r == AW'(N - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          unique case (mst_cmd_t'(item_r.command))
            CMD_ADD: begin
              if (count_r == CNT_W'(N)) begin
                res.status = ST_FULL;
              end else if (found_r) begin
                res.status = ST_PRESENT;
              end else if (free_found_r) begin
                ram_we               = 1'b1;
                ram_waddr            = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
                count_nxt            = count_r + 1'b1;
                res.status           = ST_DONE;
              end
            end
            CMD_DELETE: begin
              if (found_r) begin
                valid_nxt[match_idx_r] = 1'b0;
                count_nxt              = count_r - 1'b1;
                res.status             = ST_DONE;
              end
            end
            CMD_QUERY: begin
              if (found_r) begin
                res.status          = ST_DONE;
                res.stored_strength = match_r.strength;
                res.stored_sinr     = match_r.sinr;
                res.stored_time     = match_r.rx_time;
              end
            end
            CMD_FLUSH: begin
              valid_nxt  = '0;
              count_nxt  = '0;
              res.status = ST_DONE;
            end
            CMD_OBSERVE: begin
              if (monitor_enable && (count_r != '0) && item_r.is_mpdu && found_r) begin
                ram_we            = 1'b1;
                ram_wdata.strength = item_r.signal_strength;
                ram_wdata.sinr    = item_r.sinr_present ? sinr_stat.mean : 8'd0;
                ram_wdata.rx_time = item_r.time_now;
                res.status        = ST_DONE;
              end
            end
            default: begin
              res.status = ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cnt_ext          = {5'b0, count_nxt};
    res.entries_used = cnt_ext[4:0];
    out_data_nxt     = finish ? res : out_data_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      rd_pending_r <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      rd_pending_r <= rd_pending_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r    <= idx_r;
    match_idx_r <= match_idx_nxt;
    match_r     <= match_nxt;
    free_idx_r  <= free_idx_nxt;
    out_data_r  <= out_data_nxt;
    if (accept) begin
      item_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // station count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("station count differs from number of valid entries");

  // count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(N))
    else $error("station count above table size");

  // read data is only consumed for reads issued during the walk
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pending_r |-> $past(state_r) == S_SCAN)
    else $error("read data consumed outside the table walk");

  // memory is written only while a result is produced
  a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_valid_r)
    else $error("entry write without a result transfer");

endmodule

@@ rtl/monitored_station_table.sv @@
// Monitored station table top level: configuration register, entry memory,
// sinr mean unit and sequencer. Depends on mst_pkg, mst_entry_ram,
// mst_sinr_acc and mst_ctrl.
//
// Usage: one command per input transfer on in_valid/in_stall/in_data (add,
// delete, query, flush, packet observe); exactly one result per command on
// out_valid/out_stall/out_data with status, queried stats and station count.
// monitor_enable sits at byte address 0 of the register port; write it only
// while no command is in flight.
// Every command walks all TABLE_ENTRIES entries of the entry memory, one
// read per cycle through its single read port, then passes the drain state
// to the final state, which waits for the sinr sum and a free output
// register. The result is registered, and the next command is taken only
// once the sequencer is back in idle.
// While a result is stalled the next command is still accepted and walked;
// its result waits in the final state until the output register frees.
// Reset clears the valid bits, the station count, monitor_enable and the
// handshake state at once; the entry memory itself is not cleared.
module monitored_station_table
  import mst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mst_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mst_out_t              out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic           mon_en_r, mon_en_nxt;
  logic           cfg_wr;
  mst_in_t        item;
  logic           sinr_start;
  mst_sinr_stat_t sinr_stat;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  mst_entry_t     ram_wdata, ram_rdata;

  // register port, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_ADDR_W-1] == REG_MON_EN);
  assign mon_en_nxt = cfg_wr ? cfg_pwdata[0] : mon_en_r;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_MON_EN) ? {31'b0, mon_en_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r <= 1'b0;
    end else begin
      mon_en_r <= mon_en_nxt;
    end
  end

  // sequencer
  mst_ctrl #(
    .N     (TABLE_ENTRIES),
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .monitor_enable (mon_en_r),
    .item           (item),
    .sinr_start     (sinr_start),
    .sinr_stat      (sinr_stat),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata)
  );

  // sinr mean
  mst_sinr_acc u_sinr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sinr_start),
    .words_a (item.sinr_words_a),
    .words_b (item.sinr_words_b),
    .words_c (item.sinr_words_c),
    .words_d (item.sinr_words_d),
    .stat    (sinr_stat)
  );

  // entry memory
  mst_entry_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
